// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the coder RTL; all use clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SDX_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SDX_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/sdx_pkg.sv
// ----------------------------------------------------------------------------
// sdx_pkg
// Types, letter code table and constants for the Soundex word coder.
// ----------------------------------------------------------------------------
package sdx_pkg;

    localparam int CODE_LEN = 3;

    localparam logic [7:0] CHAR_A = 8'h61;
    localparam logic [7:0] CHAR_Z = 8'h7a;
    localparam logic [2:0] NO_DIGIT = 3'd0;

    // Digit for each letter a..z; zero means the letter gives no digit.
    localparam logic [2:0] LETTER_CODE [26] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd0, 3'd0, 3'd2, 3'd2, 3'd4, 3'd5,
        3'd5, 3'd0, 3'd1, 3'd2, 3'd6, 3'd2, 3'd3, 3'd0, 3'd1, 3'd0, 3'd2, 3'd0, 3'd2
    };

    typedef struct packed {
        logic [7:0] letter;
        logic       word_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] first_char;
        logic [2:0] digit_one;
        logic [2:0] digit_two;
        logic [2:0] digit_three;
    } result_t;

    function automatic logic [2:0] map_letter(input logic [7:0] c);
        logic [7:0] offs;
        offs = c - CHAR_A;
        if (c >= CHAR_A && c <= CHAR_Z)
            return LETTER_CODE[offs[4:0]];
        return NO_DIGIT;
    endfunction

endpackage

// File: sv/sdx_in_stage.sv
// ----------------------------------------------------------------------------
// sdx_in_stage
// Input register: holds one item until the coder takes it.
// ----------------------------------------------------------------------------
module sdx_in_stage
    import sdx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    output logic     item_valid,
    input  logic     item_take,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign in_ready   = !valid_reg || item_take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (item_take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: sv/sdx_coder.sv
// ----------------------------------------------------------------------------
// sdx_coder
// Word state and per-letter coding: map, merge, store, emit on the last item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sdx_coder
    import sdx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_take,
    input  in_item_t item,
    input  logic     res_ready,
    output logic     res_valid,
    output result_t  res
);

    logic       start_reg,  start_next;
    logic [7:0] first_reg,  first_next;
    logic [2:0] prior_reg,  prior_next;
    logic [1:0] count_reg,  count_next;
    logic [2:0] digits_reg  [CODE_LEN];
    logic [2:0] digits_next [CODE_LEN];
    logic [2:0] code;
    logic       store;

    // A mid-word item never needs the output slot.
    assign item_take = item_valid && (!item.word_end || res_ready);
    assign res_valid = item_valid && item.word_end && res_ready;
    assign code      = map_letter(item.letter);
    assign store     = !start_reg && (code != NO_DIGIT) && (code != prior_reg)
                       && (count_reg < 2'(CODE_LEN));

    always_comb
    begin
        start_next = start_reg;
        first_next = first_reg;
        prior_next = prior_reg;
        count_next = count_reg;
        for (int i = 0; i < CODE_LEN; i++)
        begin
            digits_next[i] = digits_reg[i];
        end

        if (start_reg)
        begin
            first_next = item.letter;
            start_next = 1'b0;
        end
        else if (code != NO_DIGIT)
        begin
            prior_next = code;
            if (store)
            begin
                for (int i = 0; i < CODE_LEN; i++)
                begin
                    if (count_reg == 2'(i))
                        digits_next[i] = code;
                end
                count_next = count_reg + 2'd1;
            end
        end

        res.first_char  = first_next;
        res.digit_one   = digits_next[0];
        res.digit_two   = digits_next[1];
        res.digit_three = digits_next[2];

        // Drop the word state once its code goes out.
        if (item.word_end)
        begin
            start_next = 1'b1;
            first_next = 8'd0;
            prior_next = NO_DIGIT;
            count_next = 2'd0;
            for (int i = 0; i < CODE_LEN; i++)
            begin
                digits_next[i] = NO_DIGIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= 1'b1;
            first_reg <= 8'd0;
            prior_reg <= NO_DIGIT;
            count_reg <= 2'd0;
            for (int i = 0; i < CODE_LEN; i++)
            begin
                digits_reg[i] <= NO_DIGIT;
            end
        end
        else if (item_take)
        begin
            start_reg <= start_next;
            first_reg <= first_next;
            prior_reg <= prior_next;
            count_reg <= count_next;
            for (int i = 0; i < CODE_LEN; i++)
            begin
                digits_reg[i] <= digits_next[i];
            end
        end
    end

    `SDX_ASSERT_NXT(a_clear_after_word, item_take && item.word_end, start_reg && count_reg == 2'd0)
    `SDX_ASSERT_IMP(a_count_matches_digits, 1'b1, (count_reg != 2'd0) == (digits_reg[0] != NO_DIGIT))
    `SDX_ASSERT_IMP(a_no_repeat_digit, count_reg >= 2'd2, digits_reg[0] != digits_reg[1])
    `SDX_ASSERT_IMP(a_start_empty, start_reg, count_reg == 2'd0 && prior_reg == NO_DIGIT)

endmodule

// File: sv/sdx_out_stage.sv
// ----------------------------------------------------------------------------
// sdx_out_stage
// Result register: holds a finished code until the sink takes it.
// ----------------------------------------------------------------------------
module sdx_out_stage
    import sdx_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_valid,
    output logic    res_ready,
    input  result_t res,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign res_ready  = !valid_reg || out_ready;
    assign valid_next = res_valid ? 1'b1 : ((valid_reg && out_ready) ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// File: sv/soundex_encoder_top.sv
// ----------------------------------------------------------------------------
// soundex_encoder_top
// Streaming Soundex coder: one letter per item, one code per word.
// ----------------------------------------------------------------------------
// Throughput: one letter per cycle while the sink keeps m_axis_tready high.
// A word's last letter waits in the input register; its code is then held in the result register.
// A last letter is held in the input register while an untaken code fills the
// result register; mid-word letters never wait on the sink.
// Reset (rst_n low, asynchronous) empties both stages and starts a new word.
// ----------------------------------------------------------------------------
module soundex_encoder_top
    import sdx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] letter
    input  logic        s_axis_tlast,   // word_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [7:0] first_char, [10:8] digit_one,
                                        // [13:11] digit_two, [16:14] digit_three
);

    in_item_t in_item;
    in_item_t item;
    logic     item_valid;
    logic     item_take;
    logic     res_valid;
    logic     res_ready;
    result_t  res;
    result_t  out_res;

    assign in_item.letter   = s_axis_tdata;
    assign in_item.word_end = s_axis_tlast;

    sdx_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    sdx_coder u_coder (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item),
        .res_ready  (res_ready),
        .res_valid  (res_valid),
        .res        (res)
    );

    sdx_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {7'd0, out_res.digit_three, out_res.digit_two,
                           out_res.digit_one, out_res.first_char};

endmodule

// File: verif/soundex_encoder_top_tb.sv
// ----------------------------------------------------------------------------
// soundex_encoder_top_tb
// Self-checking bench for the streaming Soundex word coder.
// ----------------------------------------------------------------------------
// Words are fed one letter per item on the slave stream. A short directed
// table covers the extremes and the tricky merge and drop cases. Random words
// follow, mostly lower case with stray bytes mixed in. Every item is run
// through a local coder. Each code word that comes out on the master stream
// is compared with the oldest predicted code. The sender works in bursts and
// the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module soundex_encoder_top_tb
    import sdx_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_LETTERS = 400;
    localparam int IDLE_LIMIT     = 4000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int DIRECTED_ROWS  = 23;

    typedef struct packed {
        logic [7:0] head;
        logic [2:0] d1;
        logic [2:0] d2;
        logic [2:0] d3;
    } word_code_t;

    // A pinned row is a one-letter word whose code is the letter with zero digits.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       pinned;
    } dir_row_t;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_CHOPPY} rx_mode_t;

    localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{8'h61, 1'b1, 1'b1},                                   // a
        '{8'h00, 1'b1, 1'b1},
        '{8'hff, 1'b1, 1'b1},
        '{"b", 1'b0, 1'b0}, '{"b", 1'b1, 1'b0},                 // first letter not merged
        '{"a", 1'b0, 1'b0}, '{"s", 1'b0, 1'b0}, '{"h", 1'b0, 1'b0},
        '{"c", 1'b0, 1'b0}, '{"r", 1'b0, 1'b0}, '{"a", 1'b0, 1'b0},
        '{"f", 1'b0, 1'b0}, '{"t", 1'b1, 1'b0},                 // merge across h
        '{"b", 1'b0, 1'b0}, '{"Z", 1'b0, 1'b0}, '{8'hff, 1'b0, 1'b0},
        '{"b", 1'b1, 1'b0},                                     // stray bytes mid-word
        '{"b", 1'b0, 1'b0}, '{"c", 1'b0, 1'b0}, '{"d", 1'b0, 1'b0},
        '{"l", 1'b0, 1'b0}, '{"m", 1'b0, 1'b0}, '{"r", 1'b1, 1'b0}  // digits past three
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    // coder state mirrored by the predictor
    logic       word_open = 1'b0;
    logic [7:0] head_char = 8'h00;
    logic [2:0] last_digit = NO_DIGIT;
    logic [2:0] held_digits [3] = '{NO_DIGIT, NO_DIGIT, NO_DIGIT};
    int         held_count = 0;

    word_code_t pending_codes [$];
    int errors = 0;
    int letters_sent = 0;
    int stray_bytes = 0;
    int codes_checked = 0;
    int burst_left = 0;
    int idle_cycles = 0;

    rx_mode_t rx_mode = RX_OPEN;
    int rx_phase = 0;
    int rx_run = 0;
    logic rx_hold = 1'b1;

    soundex_encoder_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    function automatic logic [2:0] letter_digit(input logic [7:0] ch);
        case (ch)
            "b", "f", "p", "v":                     return 3'd1;
            "c", "g", "j", "k", "q", "s", "x", "z": return 3'd2;
            "d", "t":                               return 3'd3;
            "l":                                    return 3'd4;
            "m", "n":                               return 3'd5;
            "r":                                    return 3'd6;
            default:                                return NO_DIGIT;
        endcase
    endfunction

    // Advance the word state by one letter; return 1 with the code on a word end.
    function automatic bit code_letter(input logic [7:0] ch, input logic last,
                                       output word_code_t code);
        logic [2:0] d;
        code = '0;
        if (!word_open)
        begin
            head_char = ch;
            word_open = 1'b1;
        end
        else
        begin
            d = letter_digit(ch);
            if (d != NO_DIGIT)
            begin
                if (d != last_digit && held_count < 3)
                begin
                    held_digits[held_count] = d;
                    held_count++;
                end
                last_digit = d;
            end
        end
        if (!last)
            return 1'b0;
        code = '{head_char, held_digits[0], held_digits[1], held_digits[2]};
        word_open = 1'b0;
        head_char = 8'h00;
        last_digit = NO_DIGIT;
        held_digits = '{NO_DIGIT, NO_DIGIT, NO_DIGIT};
        held_count = 0;
        return 1'b1;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_letter(input logic [7:0] ch, input logic last, input bit pinned);
        word_code_t code;
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (code_letter(ch, last, code))
            pending_codes.push_back(pinned ? word_code_t'({ch, 9'd0}) : code);
        letters_sent++;
        if (ch < "a" || ch > "z")
            stray_bytes++;
        burst_left--;
        @(negedge clk);
    endtask

    // Hold the sender until every predicted code has come out.
    task automatic drain_codes();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending_codes.size() != 0);
    endtask

    // receiver: ready pattern switches between open, random and choppy modes at random
    always @(negedge clk)
    begin
        if (rx_phase == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_phase = $urandom_range(20, 120);
        end
        else
        begin
            rx_phase--;
        end
        case (rx_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (rx_run == 0)
                begin
                    rx_run = $urandom_range(1, 12);
                    rx_hold = ~rx_hold;
                end
                rx_run--;
                m_axis_tready <= rx_hold;
            end
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_codes.size() == 0)
            begin
                $display("%0t: unexpected code, expected none, actual %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                word_code_t want;
                want = pending_codes.pop_front();
                codes_checked++;
                if (m_axis_tdata[7:0] !== want.head || m_axis_tdata[10:8] !== want.d1 ||
                    m_axis_tdata[13:11] !== want.d2 || m_axis_tdata[16:14] !== want.d3 ||
                    m_axis_tdata[23:17] !== 7'd0)
                begin
                    $display("%0t: mismatch, expected %h %0d%0d%0d, actual %h %0d%0d%0d pad %h",
                             $time, want.head, want.d1, want.d2, want.d3,
                             m_axis_tdata[7:0], m_axis_tdata[10:8], m_axis_tdata[13:11],
                             m_axis_tdata[16:14], m_axis_tdata[23:17]);
                    errors++;
                end
            end
        end
    end

    // watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: timeout with %0d codes outstanding", $time, pending_codes.size());
            $display("FAIL soundex_encoder_top");
            $finish;
        end
    end

    initial
    begin
        int words;
        int len;
        logic [7:0] ch;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_letter(DIRECTED[i].ch, DIRECTED[i].last, DIRECTED[i].pinned);
        drain_codes();

        words = 0;
        while (letters_sent < DIRECTED_ROWS + RANDOM_LETTERS)
        begin
            len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 14);
            for (int k = 0; k < len; k++)
            begin
                if ($urandom_range(0, 99) < 85)
                    ch = 8'("a" + $urandom_range(0, 25));
                else
                    ch = 8'($urandom_range(0, 255));
                send_letter(ch, k == len - 1, 1'b0);
            end
            words++;
            if (words == 15)
                drain_codes();
        end

        s_axis_tvalid <= 1'b0;
        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d letters (%0d outside a..z), checked %0d word codes.",
                 letters_sent, stray_bytes, codes_checked);
        $display("Sender ran in bursts, receiver stalled in open, random and choppy modes.");
        if (errors == 0)
            $display("PASS soundex_encoder_top");
        else
            $display("FAIL soundex_encoder_top");
        $finish;
    end

endmodule
